@@ hdl/extended_gcd_coefficients_top_assert.svh @@
// Assertion macros for the extended GCD block.
// Included by egcd_datapath, which checks its own logic; depends on clk_i and rst_ni.
`ifndef EXTENDED_GCD_COEFFICIENTS_TOP_ASSERT_SVH
`define EXTENDED_GCD_COEFFICIENTS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define EGCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define EGCD_ASSERT_NEXT(lbl, pre, post, msg) \
  `EGCD_ASSERT(lbl, (pre) |=> (post), msg)
`else
`define EGCD_ASSERT(lbl, prop, msg)
`define EGCD_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ hdl/egcd_pkg.sv @@
// Shared types, constants and the microcode ROM of the extended GCD block.
// No dependencies; imported by every module of the block.
package egcd_pkg;

  // Result width and operand width.
  localparam int unsigned Width       = 64;
  localparam int unsigned OpW         = Width - 1;
  // The multiply-subtract takes the quotient one chunk at a time.
  localparam int unsigned ChunkW      = 16;
  localparam int unsigned MulSteps    = Width / ChunkW;
  localparam int unsigned CntW        = $clog2(OpW);
  localparam int unsigned MaxStepsDef = 128;
  localparam int unsigned PcW         = 4;

  typedef struct packed {
    logic [OpW-1:0] operand_a;
    logic [OpW-1:0] operand_b;
  } egcd_in_t;

  typedef struct packed {
    logic signed [Width-1:0] coef_x;
    logic signed [Width-1:0] coef_y;
  } egcd_out_t;

  // Datapath operations, one per microinstruction.
  typedef enum logic [3:0] {
    OpNop,
    OpAccept,
    OpDivInit,
    OpDivStep,
    OpDivDone,
    OpPop,
    OpMulInit,
    OpMulStep,
    OpCombine,
    OpEmit
  } op_e;

  // Jump conditions.
  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondInIdle,
    CondStop,
    CondCntNz,
    CondDepthZero,
    CondOutFree
  } cond_e;

  typedef struct packed {
    op_e            op;
    cond_e          cond;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic in_valid;
    logic stop;
    logic cnt_nz;
    logic depth_zero;
    logic out_free;
  } egcd_status_t;

  // Microprogram addresses.
  localparam logic [PcW-1:0] PcIdle    = 4'd0;
  localparam logic [PcW-1:0] PcTest    = 4'd1;
  localparam logic [PcW-1:0] PcDivInit = 4'd2;
  localparam logic [PcW-1:0] PcDivStep = 4'd3;
  localparam logic [PcW-1:0] PcDivDone = 4'd4;
  localparam logic [PcW-1:0] PcBack    = 4'd5;
  localparam logic [PcW-1:0] PcPop     = 4'd6;
  localparam logic [PcW-1:0] PcMulInit = 4'd7;
  localparam logic [PcW-1:0] PcMulStep = 4'd8;
  localparam logic [PcW-1:0] PcCombine = 4'd9;
  localparam logic [PcW-1:0] PcEmit    = 4'd10;
  localparam logic [PcW-1:0] PcRetry   = 4'd11;

  // The program: forward pass divides and stores quotients, backward pass
  // replays them with a chunked multiply-subtract.
  function automatic ctrl_word_t ucode_rom(logic [PcW-1:0] pc);
    ctrl_word_t w;
    case (pc)
      PcIdle:    w = '{OpAccept,  CondInIdle,    PcIdle};
      PcTest:    w = '{OpNop,     CondStop,      PcBack};
      PcDivInit: w = '{OpDivInit, CondNever,     PcIdle};
      PcDivStep: w = '{OpDivStep, CondCntNz,     PcDivStep};
      PcDivDone: w = '{OpDivDone, CondAlways,    PcTest};
      PcBack:    w = '{OpNop,     CondDepthZero, PcEmit};
      PcPop:     w = '{OpPop,     CondNever,     PcIdle};
      PcMulInit: w = '{OpMulInit, CondNever,     PcIdle};
      PcMulStep: w = '{OpMulStep, CondCntNz,     PcMulStep};
      PcCombine: w = '{OpCombine, CondAlways,    PcBack};
      PcEmit:    w = '{OpEmit,    CondOutFree,   PcIdle};
      PcRetry:   w = '{OpNop,     CondAlways,    PcEmit};
      default:   w = '{OpNop,     CondAlways,    PcIdle};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/egcd_qmem.sv @@
// Quotient store of the extended GCD block: one write and one registered read port.
// Depends on egcd_pkg.
module egcd_qmem
  import egcd_pkg::*;
#(
  parameter int unsigned MaxSteps = MaxStepsDef,
  localparam int unsigned IdxW = $clog2(MaxSteps)
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [OpW-1:0]  wr_data_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [OpW-1:0]  rd_data_o
);

  logic [OpW-1:0] mem [MaxSteps];
  logic [OpW-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/egcd_useq.sv @@
// Microcode sequencer: program counter, control ROM and conditional jumps.
// Depends on egcd_pkg.
module egcd_useq
  import egcd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  egcd_status_t status_i,
  output ctrl_word_t   ctrl_o
);

  logic [PcW-1:0] pc_q, pc_d;
  ctrl_word_t     word;
  logic           take;

  assign word = ucode_rom(pc_q);

  // Evaluate the jump condition of the current word.
  always_comb begin
    case (word.cond)
      CondNever:     take = 1'b0;
      CondAlways:    take = 1'b1;
      CondInIdle:    take = !status_i.in_valid;
      CondStop:      take = status_i.stop;
      CondCntNz:     take = status_i.cnt_nz;
      CondDepthZero: take = status_i.depth_zero;
      CondOutFree:   take = status_i.out_free;
      default:       take = 1'b1;
    endcase
    pc_d = take ? word.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcIdle;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = word;

endmodule

@@ hdl/egcd_datapath.sv @@
// Datapath: serial divider, chunked multiply-subtract, quotient store and output register.
// Depends on egcd_pkg, egcd_qmem and the assertion macro header.
`include "extended_gcd_coefficients_top_assert.svh"
module egcd_datapath
  import egcd_pkg::*;
#(
  parameter int unsigned MaxSteps = MaxStepsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  ctrl_word_t   ctrl_i,
  input  logic         in_valid_i,
  input  egcd_in_t     in_req_i,
  input  logic         out_stall_i,
  output logic         out_valid_o,
  output egcd_out_t    out_rsp_o,
  output egcd_status_t status_o
);

  localparam int unsigned IdxW   = $clog2(MaxSteps);
  localparam int unsigned DepthW = $clog2(MaxSteps + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MaxSteps);

  logic [OpW-1:0]      a_q, a_d, b_q, b_d;
  logic [OpW-1:0]      rem_q, rem_d, quo_q, quo_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  logic [Width-1:0]    cx_q, cx_d, cy_q, cy_d;
  logic [Width-1:0]    mq_q, mq_d, mcand_q, mcand_d, acc_q, acc_d;
  logic                out_valid_q, out_valid_d;
  egcd_out_t           out_rsp_q;
  logic                out_free, out_load;

  logic [OpW:0]              trial, diff;
  logic                      ge;
  logic [ChunkW+Width-1:0]   prod;
  logic [OpW-1:0]            rd_data;
  logic                      wr_en;

  // Quotient store, written in the forward pass and read back in reverse.
  assign wr_en = (ctrl_i.op == OpDivDone) && (depth_q != DepthMax);

  egcd_qmem #(
    .MaxSteps (MaxSteps)
  ) u_qmem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (depth_q[IdxW-1:0]),
    .wr_data_i (quo_q),
    .rd_addr_i (IdxW'(depth_q - DepthW'(1))),
    .rd_data_o (rd_data)
  );

  // One restoring division step: shift in a dividend bit, subtract if it fits.
  assign trial = {rem_q, quo_q[OpW-1]};
  assign diff  = trial - {1'b0, b_q};
  assign ge    = !diff[OpW];

  // One chunk of quotient times the multiplicand, kept modulo the result width.
  assign prod = mq_q[ChunkW-1:0] * mcand_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (ctrl_i.op == OpEmit) && out_free;

  // Register updates chosen by the current operation.
  always_comb begin
    a_d     = a_q;
    b_d     = b_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    depth_d = depth_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    mq_d    = mq_q;
    mcand_d = mcand_q;
    acc_d   = acc_q;
    case (ctrl_i.op)
      OpAccept: begin
        if (in_valid_i) begin
          a_d     = in_req_i.operand_a;
          b_d     = in_req_i.operand_b;
          depth_d = '0;
          cx_d    = Width'(1);
          cy_d    = '0;
        end
      end
      OpDivInit: begin
        rem_d = '0;
        quo_d = a_q;
        cnt_d = CntW'(OpW - 1);
      end
      OpDivStep: begin
        rem_d = ge ? diff[OpW-1:0] : trial[OpW-1:0];
        quo_d = {quo_q[OpW-2:0], ge};
        cnt_d = cnt_q - CntW'(1);
      end
      OpDivDone: begin
        a_d     = b_q;
        b_d     = rem_q;
        depth_d = depth_q + DepthW'(1);
      end
      OpPop: begin
        depth_d = depth_q - DepthW'(1);
      end
      OpMulInit: begin
        mq_d    = {1'b0, rd_data};
        mcand_d = cy_q;
        acc_d   = '0;
        cnt_d   = CntW'(MulSteps - 1);
      end
      OpMulStep: begin
        acc_d   = acc_q + prod[Width-1:0];
        mq_d    = mq_q >> ChunkW;
        mcand_d = mcand_q << ChunkW;
        cnt_d   = cnt_q - CntW'(1);
      end
      OpCombine: begin
        cx_d = cy_q;
        cy_d = cx_q - acc_q;
      end
      default: begin
      end
    endcase
  end

  // Output register: a finished result waits here while it is stalled.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      depth_q     <= depth_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    a_q     <= a_d;
    b_q     <= b_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    cx_q    <= cx_d;
    cy_q    <= cy_d;
    mq_q    <= mq_d;
    mcand_q <= mcand_d;
    acc_q   <= acc_d;
    if (out_load) begin
      out_rsp_q.coef_x <= cx_q;
      out_rsp_q.coef_y <= cy_q;
    end
  end

  // Status seen by the sequencer.
  assign status_o.in_valid   = in_valid_i;
  assign status_o.stop       = (b_q == '0) || (depth_q == DepthMax);
  assign status_o.cnt_nz     = (cnt_q != '0);
  assign status_o.depth_zero = (depth_q == '0);
  assign status_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The recursion depth never passes the size of the quotient store.
  `EGCD_ASSERT(a_depth_bound, depth_q <= DepthMax, "quotient depth beyond store size")
  // The divider never runs on a zero divisor.
  `EGCD_ASSERT(a_div_nonzero, (ctrl_i.op == OpDivStep) |-> (b_q != '0), "division by zero")
  // The backward pass only pops when quotients remain.
  `EGCD_ASSERT(a_pop_nonempty, (ctrl_i.op == OpPop) |-> (depth_q != '0), "pop from empty store")
  // A new request is not taken in the cycle after one was accepted.
  `EGCD_ASSERT_NEXT(a_one_accept, (ctrl_i.op == OpAccept) && in_valid_i, ctrl_i.op != OpAccept, "back to back accept")

endmodule

@@ hdl/extended_gcd_coefficients_top.sv @@
// For n Euclid steps (n <= 91 for 63-bit operands) the result is formed by the bit-serial
// divider in the forward pass and the 4-chunk multiply-subtract in the backward pass.
// One request is handled at a time; the next is taken once the result is in the output
// register, which holds it while stalled.
// Reset is asynchronous and active low; it returns the sequencer to idle and
// empties the output register. The quotient store needs no clearing.
module extended_gcd_coefficients_top
  import egcd_pkg::*;
#(
  parameter int unsigned MaxSteps = MaxStepsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  egcd_in_t  in_req_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output egcd_out_t out_rsp_o
);

  ctrl_word_t   ctrl;
  egcd_status_t status;

  // Microcode sequencer.
  egcd_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Arithmetic datapath with quotient store and output register.
  egcd_datapath #(
    .MaxSteps (MaxSteps)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_valid_i  (in_valid_i),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .status_o    (status)
  );

  // A request is taken only in the idle microinstruction.
  assign in_stall_o = (ctrl.op != OpAccept);

endmodule
